>>> src/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Hold: when the antecedent is seen, the consequent must hold in the same cycle.
`define PPDR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pose block check failed");
// Next: when the antecedent is seen, the consequent must hold in the following cycle.
`define PPDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pose block sequencing check failed");
`endif

>>> src/ppdr_pkg.sv
// Package for the planar pose dead reckoning block: payload types, FSM states,
// CORDIC constants and small arithmetic helpers. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ppdr_pkg;

  localparam int ANGLE_BITS_DEF      = 16;
  localparam int POSITION_BITS_DEF   = 32;
  localparam int TRIG_ITERATIONS_DEF = 16;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [30:0] TURNS32_PER_RAD = 31'sd683565276;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_rate;
    logic        [15:0] elapsed_time;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic        [15:0] load_heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic        [15:0] heading_angle;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] speed_out;
    logic signed [15:0] rate_out;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_UPD,
    ST_CORD2,
    ST_FIN
  } state_t;

  // Control of a bit-serial multiplier.
  typedef struct packed {
    logic load;
    logic step;
  } mul_ctl_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Round a Q3.30 value to Q1.14 and clamp to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [17:0] r;
    logic signed [15:0] q;
    t = v + 34'sd32768;
    r = t[33:16];
    if (r > 18'sd16384) begin
      q = 16'sd16384;
    end else if (r < -18'sd16384) begin
      q = -16'sd16384;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

endpackage
`default_nettype wire

>>> src/planar_pose_dead_reckoning.sv
// Planar pose dead reckoning (unicycle odometry), top level.
// Depends on ppdr_pkg, ppdr_cordic, ppdr_smul and assert_macros.svh.
//
// Usage:
//  - Input channel in_valid / in_stall / in_data carries one item per transfer.
//    Opcode load writes x, y and heading and gives no result.
//    Opcode advance moves the pose by speed*dt along the old heading, turns it
//    by rate*dt and gives one result on out_valid / out_stall / out_data.
//  - An advance forms speed*dt and rate*dt in 16 serial steps, overlapped with
//    the first CORDIC pass, then the position and heading increments in 32 serial
//    steps, then commits the pose in an update state, runs the half-angle
//    quaternion pass on the new heading and finally loads the result register.
//    The next item is taken only after the result has been loaded.
//  - in_stall is high while an advance is in flight; one item at a time.
//  - The result register parts the two sides: a new item is taken while an
//    earlier result still waits. If a finished result meets a full, stalled
//    output register, hold it until the receiver takes the old one.
//  - Reset (rst_n low, synchronous) clears the pose to zero and drops any
//    pending result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module planar_pose_dead_reckoning
  import ppdr_pkg::*;
#(
  parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
  parameter int POSITION_BITS   = POSITION_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int AB = ANGLE_BITS;
  localparam int PB = POSITION_BITS;
  localparam int LW = (PB > 32) ? PB : 32;
  localparam int SH = 60 - AB;
  localparam logic [5:0] MUL1_STEPS = 6'd16;
  localparam logic [5:0] MUL2_STEPS = 6'd32;

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  logic signed [PB-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [AB-1:0]        head_r, head_nxt;
  logic signed [15:0]   speed_r, speed_nxt, rate_r, rate_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  mul_ctl_t mul1_ctl, mul2_ctl;
  logic signed [32:0] dprod, rprod;
  logic signed [65:0] xprod, yprod;
  logic signed [63:0] hprod;

  logic               cor_start, cor_busy;
  logic        [31:0] cor_angle;
  logic signed [33:0] cor_cos, cor_sin;

  logic               in_xfer, out_xfer;
  logic signed [65:0] xr, yr;
  logic signed [63:0] hr;
  logic signed [PB:0] sum_x, sum_y;
  logic [AB-1:0]      head_new;
  logic signed [LW:0] lx, ly;
  logic signed [LW-1:0] ox, oy;

  function automatic logic signed [PB-1:0] sat_sum(input logic signed [PB:0] s);
    logic signed [PB-1:0] r;
    if (s[PB] != s[PB-1]) begin
      r = s[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
    end else begin
      r = s[PB-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PB-1:0] sat_load(input logic signed [LW:0] v);
    logic signed [PB-1:0] r;
    if (v != (LW+1)'(signed'(v[PB-1:0]))) begin
      r = v[LW] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
    end else begin
      r = v[PB-1:0];
    end
    return r;
  endfunction

  // speed*dt and rate*dt
  ppdr_smul #(.MW(16), .AW(33), .PW(33)) u_mul_d (
    .clk(clk), .ctl(mul1_ctl), .mplier(in_data.forward_speed),
    .mcand(33'(signed'({1'b0, in_data.elapsed_time}))), .prod(dprod)
  );
  ppdr_smul #(.MW(16), .AW(33), .PW(33)) u_mul_r (
    .clk(clk), .ctl(mul1_ctl), .mplier(in_data.turn_rate),
    .mcand(33'(signed'({1'b0, in_data.elapsed_time}))), .prod(rprod)
  );
  // d*cos, d*sin and rate*dt*turns-per-radian
  ppdr_smul #(.MW(32), .AW(34), .PW(66)) u_mul_x (
    .clk(clk), .ctl(mul2_ctl), .mplier(dprod[31:0]), .mcand(cor_cos), .prod(xprod)
  );
  ppdr_smul #(.MW(32), .AW(34), .PW(66)) u_mul_y (
    .clk(clk), .ctl(mul2_ctl), .mplier(dprod[31:0]), .mcand(cor_sin), .prod(yprod)
  );
  ppdr_smul #(.MW(32), .AW(31), .PW(64)) u_mul_h (
    .clk(clk), .ctl(mul2_ctl), .mplier(rprod[31:0]), .mcand(TURNS32_PER_RAD),
    .prod(hprod)
  );

  ppdr_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(cor_angle),
    .busy(cor_busy), .cos_o(cor_cos), .sin_o(cor_sin)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    // round half up, then take the step
    xr       = xprod + (66'sd1 <<< 41);
    yr       = yprod + (66'sd1 <<< 41);
    hr       = hprod + (64'sd1 <<< (SH - 1));
    sum_x    = (PB+1)'(pos_x_r) + (PB+1)'(signed'(xr[65:42]));
    sum_y    = (PB+1)'(pos_y_r) + (PB+1)'(signed'(yr[65:42]));
    head_new = head_r + hr[SH+AB-1:SH];
    lx       = (LW+1)'(in_data.load_x);
    ly       = (LW+1)'(in_data.load_y);
    ox       = LW'(pos_x_r);
    oy       = LW'(pos_y_r);

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    head_nxt      = head_r;
    speed_nxt     = speed_r;
    rate_nxt      = rate_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    mul1_ctl      = '0;
    mul2_ctl      = '0;
    cor_start     = 1'b0;
    cor_angle     = {head_r, {(32-AB){1'b0}}};

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.opcode == OP_LOAD) begin
            pos_x_nxt = sat_load(lx);
            pos_y_nxt = sat_load(ly);
            head_nxt  = AB'({in_data.load_heading, 16'h0000} >> (32 - AB));
          end else begin
            mul1_ctl.load = 1'b1;
            cor_start     = 1'b1;
            speed_nxt     = in_data.forward_speed;
            rate_nxt      = in_data.turn_rate;
            cnt_nxt       = '0;
            state_nxt     = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        if (cnt_r != MUL1_STEPS) begin
          mul1_ctl.step = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end else if (!cor_busy) begin
          mul2_ctl.load = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (cnt_r != MUL2_STEPS) begin
          mul2_ctl.step = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // commit the pose and start the half-angle pass on the new heading
        pos_x_nxt = sat_sum(sum_x);
        pos_y_nxt = sat_sum(sum_y);
        head_nxt  = head_new;
        cor_start = 1'b1;
        cor_angle = {1'b0, head_new, {(31-AB){1'b0}}};
        state_nxt = ST_CORD2;
      end
      ST_CORD2: begin
        if (!cor_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.position_x    = ox[31:0];
          out_nxt.position_y    = oy[31:0];
          out_nxt.heading_angle = cor_angle[31:16];
          out_nxt.quat_z        = to_q14(cor_sin);
          out_nxt.quat_w        = to_q14(cor_cos);
          out_nxt.speed_out     = speed_r;
          out_nxt.rate_out      = rate_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      head_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      head_r      <= head_nxt;
    end
    speed_r <= speed_nxt;
    rate_r  <= rate_nxt;
    out_r   <= out_nxt;
  end

  // The first CORDIC pass must be finished before the second multiply.
  `PPDR_ASSERT_IMPL(a_cordic_done, clk, rst_n, state_r == ST_MUL2, !cor_busy)
  // A load transfer leaves the sequencer idle.
  `PPDR_ASSERT_NEXT(a_load_idle, clk, rst_n,
    in_xfer && in_data.opcode == OP_LOAD, state_r == ST_IDLE)
  // Advancing out of the final state always leaves a result waiting.
  `PPDR_ASSERT_NEXT(a_fin_result, clk, rst_n,
    state_r == ST_FIN && state_nxt == ST_IDLE, out_valid_r)

endmodule
`default_nettype wire

>>> src/ppdr_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ppdr_pkg for the start vector and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module ppdr_cordic
  import ppdr_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic        [31:0] angle,
  output logic                    busy,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);

  localparam int IW = $clog2(TRIG_ITERATIONS);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic               busy_r, busy_nxt, flip_r, flip_nxt;
  logic signed [33:0] dx, dy, at;
  logic               flip_in;

  always_comb begin
    flip_in  = angle[31] ^ angle[30];
    dx       = y_r >>> i_r;
    dy       = x_r >>> i_r;
    at       = 34'(signed'({1'b0, atan_turns(5'(i_r))}));
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    if (start) begin
      // fold the left half plane onto the right by a half turn
      flip_nxt = flip_in;
      z_nxt    = 34'(signed'({angle[31] ^ flip_in, angle[30:0]}));
      x_nxt    = CORDIC_START;
      y_nxt    = '0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      if (i_r == IW'(TRIG_ITERATIONS - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    i_r    <= i_nxt;
    flip_r <= flip_nxt;
  end

  assign busy  = busy_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule
`default_nettype wire

>>> src/ppdr_smul.sv
// Bit-serial signed multiplier, multiplier bits taken MSB first, one per step.
// Depends on ppdr_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none
module ppdr_smul
  import ppdr_pkg::*;
#(
  parameter int MW = 16,
  parameter int AW = 33,
  parameter int PW = 33
) (
  input  wire logic                 clk,
  input  wire mul_ctl_t             ctl,
  input  wire logic        [MW-1:0] mplier,
  input  wire logic signed [AW-1:0] mcand,
  output logic signed      [PW-1:0] prod
);

  logic [MW-1:0]        sr_r;
  logic signed [AW-1:0] m_r;
  logic signed [PW-1:0] acc_r, mext, term;
  logic                 first_r;

  always_comb begin
    mext = PW'(m_r);
    term = '0;
    if (sr_r[MW-1]) begin
      // the sign bit carries negative weight
      term = first_r ? -mext : mext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sr_r    <= mplier;
      m_r     <= mcand;
      acc_r   <= '0;
      first_r <= 1'b1;
    end else if (ctl.step) begin
      sr_r    <= {sr_r[MW-2:0], 1'b0};
      acc_r   <= (acc_r <<< 1) + term;
      first_r <= 1'b0;
    end
  end

  assign prod = acc_r;

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for planar_pose_dead_reckoning: directed table, then random
// advance/load traffic with bursty sender and stalling receiver. Depends on ppdr_pkg.
`timescale 1ns / 1ps
module tb;
  import ppdr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  planar_pose_dead_reckoning DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the pose as the block should hold it.
  logic signed [31:0] pose_x, pose_y;
  logic [15:0] pose_h;
  out_t pose_queue[$];
  int mismatches = 0;
  bit hold_off = 1'b0;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rotation-mode CORDIC on a 32-bit binary angle; gives Q2.30 cos and sin.
  task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] atan_v[16];
    longint x, y, z, dx, dy;
    bit flip;
    atan_v = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
               32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
               32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
               32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang + 32'h80000000;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_v[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_v[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic logic signed [15:0] round_q14(longint v);
    longint r;
    r = shr_floor(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // Advance the predicted pose for one transfer; queue the result it causes.
  task automatic step_pose(input in_t it);
    longint d, c, s, p;
    out_t res;
    if (it.opcode == OP_LOAD) begin
      pose_x = it.load_x;
      pose_y = it.load_y;
      pose_h = it.load_heading;
      return;
    end
    d = longint'(it.forward_speed) * longint'({1'b0, it.elapsed_time});
    rotate_unit({pose_h, 16'h0}, c, s);
    pose_x = clamp32(longint'(pose_x) + shr_floor(d * c + (64'sd1 <<< 41), 42));
    pose_y = clamp32(longint'(pose_y) + shr_floor(d * s + (64'sd1 <<< 41), 42));
    p = longint'(it.turn_rate) * longint'({1'b0, it.elapsed_time}) * 683565276;
    p = shr_floor(p + (64'sd1 <<< 43), 44);
    pose_h = pose_h + p[15:0];
    rotate_unit({1'b0, pose_h, 15'h0}, c, s);
    res.position_x = pose_x;
    res.position_y = pose_y;
    res.heading_angle = pose_h;
    res.quat_z = round_q14(s);
    res.quat_w = round_q14(c);
    res.speed_out = it.forward_speed;
    res.rate_out = it.turn_rate;
    pose_queue.push_back(res);
  endtask

  // Offer one item at the falling edge and hold it until the transfer.
  task automatic send_item(input in_t it);
    @(negedge clk);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_pose(it);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic in_t make_advance(int v, int r, int t);
    in_t it;
    it = '0;
    it.opcode = OP_ADVANCE;
    it.forward_speed = 16'(v);
    it.turn_rate = 16'(r);
    it.elapsed_time = 16'(t);
    it.load_x = $urandom;
    it.load_y = $urandom;
    it.load_heading = 16'($urandom);
    return it;
  endfunction

  function automatic in_t make_load(logic [31:0] x, logic [31:0] y, logic [15:0] h);
    in_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.forward_speed = 16'($urandom);
    it.turn_rate = 16'($urandom);
    it.elapsed_time = 16'($urandom);
    it.load_x = x;
    it.load_y = y;
    it.load_heading = h;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return make_load($urandom, $urandom, 16'($urandom));
    if (sel == 1)
      return make_advance($urandom, $urandom, $urandom);
    // Mostly short steps with modest speeds, so the pose wanders without pinning.
    it = make_advance($signed(16'($urandom_range(0, 16383))) - 8192,
                      $signed(16'($urandom_range(0, 16383))) - 8192,
                      $urandom_range(0, 6554));
    return it;
  endfunction

  // Directed table; rows with a typed result are checked on their own too.
  typedef struct {
    in_t stim;
    bit known;
    out_t want;
  } row_t;

  row_t rows[$];

  task automatic add_row(input in_t it, input bit known, input out_t want);
    row_t r;
    r.stim = it;
    r.known = known;
    r.want = want;
    rows.push_back(r);
  endtask

  // Receiver: stall on its own pattern; a long hold-off when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1'b1;
      else case ($urandom_range(0, 3))
        0: out_stall <= 1'b1;
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = pose_queue.pop_front();
        if (exp_r.position_x !== out_data.position_x ||
            exp_r.position_y !== out_data.position_y ||
            exp_r.heading_angle !== out_data.heading_angle ||
            exp_r.quat_z !== out_data.quat_z || exp_r.quat_w !== out_data.quat_w ||
            exp_r.speed_out !== out_data.speed_out ||
            exp_r.rate_out !== out_data.rate_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_r, out_data);
        end
      end
    end
  end

  task automatic drain_results();
    while (pose_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_t want;
    int burst;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero step from reset: pose stays at origin, quaternion is identity.
    want = '0;
    want.quat_w = 16'sd16384;
    add_row(make_advance(0, 0, 0), 1'b1, want);
    want.speed_out = 16'sh7fff;
    want.rate_out = 16'sh8000;
    add_row(make_advance(16'sh7fff, 16'sh8000, 0), 1'b1, want);
    add_row(make_advance(16'sh7fff, 0, 16'hffff), 1'b0, want);
    add_row(make_advance(16'sh8000, 16'sh7fff, 16'hffff), 1'b0, want);
    add_row(make_advance(16'sh8000, 16'sh8000, 16'hffff), 1'b0, want);
    // Positions at the extremes, then drive into saturation.
    add_row(make_load(32'h7fff0000, 32'h80010000, 16'h0000), 1'b0, want);
    add_row(make_advance(16'sh7fff, 0, 16'hffff), 1'b0, want);
    add_row(make_load(32'h80000000, 32'h7fffffff, 16'h8000), 1'b0, want);
    add_row(make_advance(16'sh7fff, 0, 16'hffff), 1'b0, want);
    add_row(make_load(32'h7fffffff, 32'h80000000, 16'h4000), 1'b0, want);
    add_row(make_advance(16'sh8000, 0, 16'hffff), 1'b0, want);
    add_row(make_load(0, 0, 16'hc000), 1'b0, want);
    add_row(make_advance(16'sh1000, 0, 16'h1000), 1'b0, want);
    add_row(make_load(0, 0, 16'hffff), 1'b0, want);
    add_row(make_advance(16'sh1000, 16'sh0001, 16'h0001), 1'b0, want);
    add_row(make_load(0, 0, 16'h7fff), 1'b0, want);
    add_row(make_advance(0, 16'sh0010, 16'h0100), 1'b0, want);
    add_row(make_load(32'hffffffff, 32'h00000001, 16'h8001), 1'b0, want);
    add_row(make_advance(16'shffff, 16'shffff, 16'h0001), 1'b0, want);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        // The typed row must agree with the predictor, or the bench is wrong.
        send_item(rows[i].stim);
        if (pose_queue[$] !== rows[i].want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: expected %h predicted %h", i, rows[i].want,
                     pose_queue[$]);
        end
      end else begin
        send_item(rows[i].stim);
      end
      if ($urandom_range(0, 1)) repeat ($urandom_range(0, 5)) @(posedge clk);
    end
    drain_results();

    // Pressure: receiver holds off while the sender keeps offering.
    fork
      begin
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 6; k++) send_item(random_item());
    join
    drain_results();

    for (int n = 0; n < 830; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < 830; b++, n++) send_item(random_item());
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 90)) @(posedge clk);
    end
    drain_results();
    repeat (100) @(posedge clk);

    if (mismatches == 0 && pose_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/ppdr_pkg.sv
src/ppdr_cordic.sv
src/ppdr_smul.sv
src/planar_pose_dead_reckoning.sv
verif/tb.sv
